// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file mi3_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_HOLDS(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AST_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that is also checked through reset.
`define AST_NEXT_ANY(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/mi3_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mi3_pkg;

    // Entry format: signed fixed point.
    localparam int EW = 32;
    localparam int FB = 16;

    // Internal widths, all exact.
    localparam int PW  = 2 * EW;         // entry product
    localparam int AW  = 2 * EW + 1;     // cofactor
    localparam int HW  = 2 * EW + 1;     // determinant partial product
    localparam int TW  = 3 * EW + 1;     // determinant term
    localparam int DW  = 3 * EW + 3;     // determinant
    localparam int NW  = AW + 2 * FB;    // scaled numerator
    localparam int RW  = DW + EW;        // divider remainder

    // Pipeline stage count from input register to output register.
    localparam int NST = EW + 9;

    // Cofactor k is a[ADJ_A]*a[ADJ_B] - a[ADJ_C]*a[ADJ_D], entries in row-major order.
    localparam int ADJ_A [9] = '{4, 7, 1, 5, 8, 2, 3, 6, 0};
    localparam int ADJ_B [9] = '{8, 2, 5, 6, 0, 3, 7, 1, 4};
    localparam int ADJ_C [9] = '{5, 8, 2, 3, 6, 0, 4, 7, 1};
    localparam int ADJ_D [9] = '{7, 1, 4, 8, 2, 5, 6, 0, 3};

    typedef struct packed {
        logic signed [EW-1:0] a00;
        logic signed [EW-1:0] a01;
        logic signed [EW-1:0] a02;
        logic signed [EW-1:0] a10;
        logic signed [EW-1:0] a11;
        logic signed [EW-1:0] a12;
        logic signed [EW-1:0] a20;
        logic signed [EW-1:0] a21;
        logic signed [EW-1:0] a22;
    } in_t;

    typedef struct packed {
        logic signed [EW-1:0] b00;
        logic signed [EW-1:0] b01;
        logic signed [EW-1:0] b02;
        logic signed [EW-1:0] b10;
        logic signed [EW-1:0] b11;
        logic signed [EW-1:0] b12;
        logic signed [EW-1:0] b20;
        logic signed [EW-1:0] b21;
        logic signed [EW-1:0] b22;
        logic                 singular;
    } out_t;

    // Side flags that travel with one quotient.
    typedef struct packed {
        logic sat;
        logic neg;
    } div_flags_t;

endpackage
`default_nettype wire

// ===== rtl/core/mi3_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per stage, most significant bit first.
module mi3_div import mi3_pkg::*; (
    input  wire logic             aclk,
    input  wire logic [EW-1:0]    en,
    input  wire logic [RW-1:0]    num_mag,
    input  wire logic [DW-1:0]    den_mag,
    input  wire div_flags_t       flags_in,
    output logic      [EW-1:0]    q_out,
    output div_flags_t            flags_out
);

    logic [RW-1:0] rem_reg   [EW];
    logic [EW-1:0] q_reg     [EW];
    logic [DW-1:0] den_reg   [EW];
    div_flags_t    flags_reg [EW];

    for (genvar k = 0; k < EW; k++) begin : g_stage
        logic [RW-1:0] rem_i;
        logic [EW-1:0] q_i;
        logic [DW-1:0] den_i;
        div_flags_t    flags_i;
        logic [RW-1:0] dsh;
        logic          ge;
        logic [RW-1:0] rem_next;
        logic [EW-1:0] q_next;

        if (k == 0) begin : g_first
            assign rem_i   = num_mag;
            assign q_i     = '0;
            assign den_i   = den_mag;
            assign flags_i = flags_in;
        end else begin : g_rest
            assign rem_i   = rem_reg[k-1];
            assign q_i     = q_reg[k-1];
            assign den_i   = den_reg[k-1];
            assign flags_i = flags_reg[k-1];
        end

        // Trial subtract of the divisor aligned to this quotient bit.
        always_comb begin
            dsh      = {{EW{1'b0}}, den_i} << (EW - 1 - k);
            ge       = (rem_i >= dsh);
            rem_next = ge ? (rem_i - dsh) : rem_i;
            q_next   = q_i;
            q_next[EW-1-k] = ge;
        end

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                rem_reg[k]   <= rem_next;
                q_reg[k]     <= q_next;
                den_reg[k]   <= den_i;
                flags_reg[k] <= flags_i;
            end
        end
    end

    assign q_out     = q_reg[EW-1];
    assign flags_out = flags_reg[EW-1];

endmodule
`default_nettype wire

// ===== rtl/core/matrix3_inverse_top.sv =====
// 3x3 matrix inverse, signed Q16.16 in and out.
// Input channel s_valid/s_ready/s_data carries one matrix per request; the
// result channel m_valid/m_ready/m_data carries its inverse and a singular
// flag. Every matrix gives exactly one result, in order.
// From an accepted request to m_valid a matrix passes the input register,
// products, cofactors, determinant and magnitude setup, then 32 divider
// stages (one quotient bit per stage), then the output register.
// Throughput is one matrix per cycle while m_ready is high; nine divider
// lanes run side by side. Each stage advances when it is empty or the stage
// after it advances, so when the receiver holds m_ready low the pipeline
// keeps filling its empty stages and s_ready only falls once every stage
// holds a request. Reset (aresetn low, synchronous) clears all valid bits;
// data registers are not reset. A zero determinant gives singular = 1 and
// all entries 0; out-of-range entries saturate to the 32-bit limits.
`timescale 1ns / 1ps
`default_nettype none
module matrix3_inverse_top import mi3_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    localparam int SDIV = 8;        // first divider stage
    localparam int SOUT = NST - 1;  // output stage

    // Stage valid bits and advance enables.
    logic [NST-1:0] v_reg, v_next, en, vin;

    assign en[SOUT] = !v_reg[SOUT] || m_ready;
    for (genvar i = 0; i < NST - 1; i++) begin : g_en
        assign en[i] = !v_reg[i] || en[i+1];
    end

    assign vin    = {v_reg[NST-2:0], s_valid};
    assign v_next = (en & vin) | (~en & v_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_ready = en[0];
    assign m_valid = v_reg[SOUT];

    // Stage 0: input register.
    logic signed [EW-1:0] a_in  [9];
    logic signed [EW-1:0] a_reg [9];

    assign a_in[0] = s_data.a00;
    assign a_in[1] = s_data.a01;
    assign a_in[2] = s_data.a02;
    assign a_in[3] = s_data.a10;
    assign a_in[4] = s_data.a11;
    assign a_in[5] = s_data.a12;
    assign a_in[6] = s_data.a20;
    assign a_in[7] = s_data.a21;
    assign a_in[8] = s_data.a22;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            a_reg <= a_in;
        end
    end

    // Stage 1: the eighteen entry products.
    logic signed [PW-1:0] p1_reg [9];
    logic signed [PW-1:0] p2_reg [9];
    logic signed [EW-1:0] r0_1_reg [3];

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            for (int k = 0; k < 9; k++) begin
                p1_reg[k] <= a_reg[ADJ_A[k]] * a_reg[ADJ_B[k]];
                p2_reg[k] <= a_reg[ADJ_C[k]] * a_reg[ADJ_D[k]];
            end
            for (int j = 0; j < 3; j++) begin
                r0_1_reg[j] <= a_reg[j];
            end
        end
    end

    // Stage 2: cofactors.
    logic signed [AW-1:0] adj2_reg [9];
    logic signed [EW-1:0] r0_2_reg [3];

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            for (int k = 0; k < 9; k++) begin
                adj2_reg[k] <= {p1_reg[k][PW-1], p1_reg[k]} - {p2_reg[k][PW-1], p2_reg[k]};
            end
            r0_2_reg <= r0_1_reg;
        end
    end

    // Stage 3: determinant partial products, cofactor split into high and low halves.
    logic signed [HW-1:0] lo3_reg [3];
    logic signed [HW-1:0] hi3_reg [3];
    logic signed [AW-1:0] adj3_reg [9];

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            for (int j = 0; j < 3; j++) begin
                lo3_reg[j] <= $signed({1'b0, adj2_reg[3*j][EW-1:0]}) * r0_2_reg[j];
                hi3_reg[j] <= $signed(adj2_reg[3*j][AW-1:EW]) * r0_2_reg[j];
            end
            adj3_reg <= adj2_reg;
        end
    end

    // Stage 4: recombine the halves into three exact terms.
    logic signed [TW-1:0] term4_reg [3];
    logic signed [AW-1:0] adj4_reg  [9];

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            for (int j = 0; j < 3; j++) begin
                term4_reg[j] <= ({{EW{hi3_reg[j][HW-1]}}, hi3_reg[j]} <<< EW)
                              + {{EW{lo3_reg[j][HW-1]}}, lo3_reg[j]};
            end
            adj4_reg <= adj3_reg;
        end
    end

    // Stage 5: determinant.
    logic signed [DW-1:0] det5_reg;
    logic signed [AW-1:0] adj5_reg [9];

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            det5_reg <= {{2{term4_reg[0][TW-1]}}, term4_reg[0]}
                      + {{2{term4_reg[1][TW-1]}}, term4_reg[1]}
                      + {{2{term4_reg[2][TW-1]}}, term4_reg[2]};
            adj5_reg <= adj4_reg;
        end
    end

    // Stage 6: magnitudes and signs of numerators and determinant.
    logic [DW-1:0] den6_reg;
    logic          sing6_reg;
    logic [NW-1:0] num6_reg [9];
    logic          neg6_reg [9];
    logic [NW-1:0] num_full [9];

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            num_full[k] = {adj5_reg[k], {(2*FB){1'b0}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            den6_reg  <= det5_reg[DW-1] ? (-det5_reg) : det5_reg;
            sing6_reg <= (det5_reg == '0);
            for (int k = 0; k < 9; k++) begin
                num6_reg[k] <= adj5_reg[k][AW-1] ? (-num_full[k]) : num_full[k];
                neg6_reg[k] <= adj5_reg[k][AW-1] ^ det5_reg[DW-1];
            end
        end
    end

    // Stage 7: quotient of 2^EW or more always saturates.
    logic [DW-1:0]    den7_reg;
    logic             sing7_reg;
    logic [RW-1:0]    num7_reg   [9];
    div_flags_t       flags7_reg [9];

    always_ff @(posedge aclk) begin
        if (en[7]) begin
            den7_reg  <= den6_reg;
            sing7_reg <= sing6_reg;
            for (int k = 0; k < 9; k++) begin
                num7_reg[k]       <= {{(RW-NW){1'b0}}, num6_reg[k]};
                flags7_reg[k].sat <= ({{(RW-NW){1'b0}}, num6_reg[k]} >= {den6_reg, {EW{1'b0}}});
                flags7_reg[k].neg <= neg6_reg[k];
            end
        end
    end

    // Divider lanes, one per inverse entry.
    logic [EW-1:0] q_lane     [9];
    div_flags_t    flags_lane [9];

    for (genvar k = 0; k < 9; k++) begin : g_lane
        mi3_div u_div (
            .aclk      (aclk),
            .en        (en[SDIV+EW-1:SDIV]),
            .num_mag   (num7_reg[k]),
            .den_mag   (den7_reg),
            .flags_in  (flags7_reg[k]),
            .q_out     (q_lane[k]),
            .flags_out (flags_lane[k])
        );
    end

    // Singular flag rides alongside the divider stages.
    logic sing_dly_reg [EW];

    always_ff @(posedge aclk) begin
        for (int i = 0; i < EW; i++) begin
            if (en[SDIV+i]) begin
                sing_dly_reg[i] <= (i == 0) ? sing7_reg : sing_dly_reg[(i == 0) ? 0 : i-1];
            end
        end
    end

    // Output stage: sign, saturation and the singular case.
    logic [EW-1:0] b_val [9];

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            if (sing_dly_reg[EW-1]) begin
                b_val[k] = '0;
            end else if (flags_lane[k].neg) begin
                if (flags_lane[k].sat || (q_lane[k][EW-1] && (|q_lane[k][EW-2:0]))) begin
                    b_val[k] = {1'b1, {(EW-1){1'b0}}};
                end else begin
                    b_val[k] = -q_lane[k];
                end
            end else begin
                if (flags_lane[k].sat || q_lane[k][EW-1]) begin
                    b_val[k] = {1'b0, {(EW-1){1'b1}}};
                end else begin
                    b_val[k] = q_lane[k];
                end
            end
        end
    end

    out_t out_reg;

    always_ff @(posedge aclk) begin
        if (en[SOUT]) begin
            out_reg.b00      <= b_val[0];
            out_reg.b01      <= b_val[1];
            out_reg.b02      <= b_val[2];
            out_reg.b10      <= b_val[3];
            out_reg.b11      <= b_val[4];
            out_reg.b12      <= b_val[5];
            out_reg.b20      <= b_val[6];
            out_reg.b21      <= b_val[7];
            out_reg.b22      <= b_val[8];
            out_reg.singular <= sing_dly_reg[EW-1];
        end
    end

    assign m_data = out_reg;

endmodule
`default_nettype wire

// ===== rtl/core/mi3_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Port-level checks on the matrix inverse.
module mi3_chk import mi3_pkg::*; (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire out_t m_data
);

    // A stalled result holds its value.
    `AST_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // A singular result carries all-zero entries.
    `AST_HOLDS(a_sing_zero, aclk, aresetn, m_valid && m_data.singular,
        m_data.b00 == '0 && m_data.b01 == '0 && m_data.b02 == '0 && m_data.b10 == '0 && m_data.b11 == '0 && m_data.b12 == '0 && m_data.b20 == '0 && m_data.b21 == '0 && m_data.b22 == '0)

    // Reset empties the pipeline.
    `AST_NEXT_ANY(a_reset_empty, aclk, !aresetn, !m_valid)

    // With no result waiting, a new request is always taken.
    `AST_HOLDS(a_ready_free, aclk, aresetn, !m_valid, s_ready)

    // While the receiver is ready, a pending request is always taken.
    `AST_HOLDS(a_flow, aclk, aresetn, s_valid && m_ready, s_ready)

endmodule

bind matrix3_inverse_top mi3_chk u_mi3_chk (.*);
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import mi3_pkg::*;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    // Probability of an idle cycle on each side, in percent.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    bit hold_off = 1'b0;
    int unsigned hold_cycles = 0;

    out_t inverse_queue[$];
    int   error_count = 0;
    bit   stim_done = 1'b0;

    // One directed row: a matrix and, where obvious, its known inverse.
    typedef struct {
        in_t  mat;
        bit   known;
        out_t inv;
    } dir_row_t;

    localparam logic signed [EW-1:0] ONE  = 32'sh0001_0000;
    localparam logic signed [EW-1:0] MAXV = 32'sh7fff_ffff;
    localparam logic signed [EW-1:0] MINV = 32'sh8000_0000;

    matrix3_inverse_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #5 aclk = ~aclk;

    // Signed quotient truncated toward zero, saturated to the entry width.
    function automatic logic signed [EW-1:0] div_saturate(logic signed [255:0] num,
                                                          logic signed [255:0] den);
        logic signed [255:0] q;
        q = num / den;
        if (q > $signed({{(256-EW){1'b0}}, MAXV})) return MAXV;
        if (q < -$signed(256'sd1 <<< (EW-1))) return MINV;
        return q[EW-1:0];
    endfunction

    // Adjugate over the determinant, exact at 256 bits.
    function automatic out_t invert_matrix(in_t m);
        logic signed [255:0] e[9];
        logic signed [255:0] adj[9];
        logic signed [255:0] det;
        logic signed [EW-1:0] b[9];
        out_t r;
        e[0] = m.a00; e[1] = m.a01; e[2] = m.a02;
        e[3] = m.a10; e[4] = m.a11; e[5] = m.a12;
        e[6] = m.a20; e[7] = m.a21; e[8] = m.a22;
        adj[0] = e[4]*e[8] - e[5]*e[7];
        adj[1] = e[7]*e[2] - e[8]*e[1];
        adj[2] = e[1]*e[5] - e[2]*e[4];
        adj[3] = e[5]*e[6] - e[3]*e[8];
        adj[4] = e[8]*e[0] - e[6]*e[2];
        adj[5] = e[2]*e[3] - e[0]*e[5];
        adj[6] = e[3]*e[7] - e[4]*e[6];
        adj[7] = e[6]*e[1] - e[7]*e[0];
        adj[8] = e[0]*e[4] - e[1]*e[3];
        det = e[0]*adj[0] + e[1]*adj[3] + e[2]*adj[6];
        r = '0;
        if (det == 0) begin
            r.singular = 1'b1;
            return r;
        end
        for (int k = 0; k < 9; k++)
            b[k] = div_saturate(adj[k] <<< (2*FB), det);
        r = '{b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7], b[8], 1'b0};
        return r;
    endfunction

    function automatic in_t diag(logic signed [EW-1:0] d0, logic signed [EW-1:0] d1,
                                 logic signed [EW-1:0] d2);
        diag = '0;
        diag.a00 = d0; diag.a11 = d1; diag.a22 = d2;
    endfunction

    function automatic logic signed [EW-1:0] rand_entry(int mode);
        case (mode)
            0: return $urandom();
            1: return $signed(32'($urandom_range(0, 32'h0004_0000))) - 32'sh0002_0000;
            2: return $urandom_range(0, 3) == 0 ? MAXV : MINV;
            default: return $signed(32'($urandom_range(0, 16))) - 32'sh8;
        endcase
    endfunction

    // Mostly well-conditioned matrices, some wild ones, some singular.
    function automatic in_t rand_matrix();
        in_t m;
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 5) begin
            m = {rand_entry(1), rand_entry(1), rand_entry(1), rand_entry(1),
                 rand_entry(1), rand_entry(1), rand_entry(1), rand_entry(1), rand_entry(1)};
        end else if (mode < 7) begin
            m = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom(), $urandom(), $urandom(), $urandom()};
        end else if (mode == 7) begin
            m = {rand_entry(3), rand_entry(2), rand_entry(3), rand_entry(2),
                 rand_entry(3), rand_entry(2), rand_entry(3), rand_entry(2), rand_entry(3)};
        end else begin
            // Row 2 repeats row 0, so the determinant is zero.
            m = {rand_entry(0), rand_entry(0), rand_entry(0), rand_entry(1),
                 rand_entry(1), rand_entry(1), 96'h0};
            m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02;
        end
        return m;
    endfunction

    // Offer one request and wait for it to be accepted. Valid stays high
    // between back-to-back requests and only drops for idle cycles.
    task automatic send_matrix(in_t m, out_t want);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= m;
        inverse_queue.push_back(want);
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        while (inverse_queue.size() != 0) @(posedge aclk);
    endtask

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(posedge aclk) begin
        if (hold_off) begin
            m_ready <= 1'b0;
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles >= 200) begin
                hold_off <= 1'b0;
                hold_cycles <= 0;
            end
        end else begin
            m_ready <= !(recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Compare each accepted result with the oldest expected inverse.
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (inverse_queue.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, m_data);
                error_count++;
            end else begin
                want = inverse_queue.pop_front();
                if (want !== m_data) begin
                    $display("%0t: mismatch, expected %h actual %h", $time, want, m_data);
                    error_count++;
                end
            end
        end
    end

    // Stimulus: directed table, then random phases with different idling.
    initial begin
        dir_row_t rows[$];
        dir_row_t row;
        out_t zero_out;
        in_t  m;
        zero_out = '0;
        zero_out.singular = 1'b1;

        row.known = 1'b1; row.mat = diag(ONE, ONE, ONE);
        row.inv = '0; row.inv.b00 = ONE; row.inv.b11 = ONE; row.inv.b22 = ONE;
        rows.push_back(row);
        row.mat = '0; row.inv = zero_out; rows.push_back(row);
        row.mat = {9{MAXV}}; row.inv = zero_out; rows.push_back(row);
        row.mat = {9{MINV}}; row.inv = zero_out; rows.push_back(row);
        row.mat = {9{32'shffff_ffff}}; row.inv = zero_out; rows.push_back(row);
        // Tiny diagonal: inverse saturates high.
        row.mat = diag(32'sd1, 32'sd1, 32'sd1);
        row.inv = '0; row.inv.b00 = MAXV; row.inv.b11 = MAXV; row.inv.b22 = MAXV;
        rows.push_back(row);
        row.mat = diag(-32'sd1, -32'sd1, -32'sd1);
        row.inv = '0; row.inv.b00 = MINV; row.inv.b11 = MINV; row.inv.b22 = MINV;
        rows.push_back(row);
        row.known = 1'b0;
        row.mat = diag(MAXV, MAXV, MAXV); rows.push_back(row);
        row.mat = diag(MINV, MINV, MINV); rows.push_back(row);
        row.mat = diag(MINV, MAXV, MINV); rows.push_back(row);
        row.mat = diag(-ONE, 32'sh0002_0000, 32'sh0000_8000); rows.push_back(row);
        row.mat = {MAXV, MINV, ONE, MINV, MAXV, -ONE, ONE, ONE, MAXV}; rows.push_back(row);
        row.mat = {ONE, 32'sh2_0000, 32'sh3_0000, 32'sh4_0000, 32'sh5_0000,
                   32'sh6_0000, 32'sh7_0000, 32'sh8_0000, 32'sh9_0000};
        rows.push_back(row);
        row.mat = {32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa,
                   32'sh5555_5555, 32'shaaaa_aaaa, 32'sh1234_5678, 32'sh0, 32'sh5555_5555};
        rows.push_back(row);
        row.mat = {ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, ONE, 32'sd0, ONE, 32'sd0};
        rows.push_back(row);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Typed-in rows are checked against their listed inverse, the rest
        // against the predictor.
        foreach (rows[i]) begin
            send_matrix(rows[i].mat,
                        rows[i].known ? rows[i].inv : invert_matrix(rows[i].mat));
        end

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 52 : (ph == 3) ? 38 : 0;
            recv_stall_pct = (ph == 2) ? 52 : (ph == 3) ? 38 : 0;
            if (ph == 0) hold_off <= 1'b1;
            for (int n = 0; n < 220; n++) begin
                m = rand_matrix();
                send_matrix(m, invert_matrix(m));
            end
        end

        s_valid <= 1'b0;
        drain();
        stim_done = 1'b1;
    end

    // Wrap up once the last result is in and the pipeline has settled.
    initial begin
        wait (stim_done);
        repeat (NST + 20) @(posedge aclk);
        if (error_count == 0 && inverse_queue.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
